// ===== src/mcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsm_pkg
// shared types, constants and hash helpers for the code signature matcher
// ----------------------------------------------------------------------------
package mcsm_pkg;

    localparam int DATA_W = 32;
    localparam int WORDS  = 16;
    localparam int IDX_W  = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    localparam logic [DATA_W-1:0] SIG_PRIME   = 32'hb503198f;
    localparam logic [DATA_W-1:0] MIX_MUL     = 32'h27d4eb2f;
    localparam logic [DATA_W-1:0] SUM_START   = 32'h5810d659;
    localparam logic [DATA_W-1:0] RET_WORD    = 32'h03e00008;
    localparam logic [DATA_W-1:0] UPPER_MASK  = 32'hffff0000;
    localparam logic [DATA_W-1:0] OPCODE_MASK = 32'hfc000000;
    localparam logic [DATA_W-1:0] MIX_XOR     = 32'd61;

    localparam logic [DATA_W-1:0] FIELD_MASK_RST = 32'h14880000;
    localparam logic [DATA_W-1:0] SIG_B_RST      = 32'h54d4eeaa;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_MASK  = 3'd0,
        CFG_SIG_B_VALUE = 3'd1,
        CFG_SIG_B_VALID = 3'd2,
        CFG_SIG_C_VALUE = 3'd3,
        CFG_SIG_C_VALID = 3'd4,
        CFG_PERMISSIVE  = 3'd5
    } t_cfg_idx;

    // per-word masking selector
    typedef enum logic [1:0] {
        MASK_WHOLE  = 2'd0,
        MASK_UPPER  = 2'd1,
        MASK_OPC_A  = 2'd2,
        MASK_OPC_B  = 2'd3
    } t_mask_sel;

    // result status
    typedef enum logic [1:0] {
        ST_MATCHED = 2'd0,
        ST_PATCHED = 2'd1,
        ST_CONT    = 2'd2,
        ST_STOP    = 2'd3
    } t_status;

    // operands handed to the shared multiplier
    typedef struct packed {
        logic [DATA_W-1:0] opa;
        logic [DATA_W-1:0] opb;
    } t_mul_req;

    // hash steps ahead of the multiply
    function automatic logic [DATA_W-1:0] pre_mix(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] a;
        a = (x ^ MIX_XOR) ^ (x >> 16);
        a = a + (a << 3);
        a = a ^ (a >> 4);
        return a;
    endfunction

    // hash step after the multiply
    function automatic logic [DATA_W-1:0] post_mix(input logic [DATA_W-1:0] x);
        return x ^ (x >> 15);
    endfunction

endpackage

// ===== src/mcsm_mul.sv =====
// ----------------------------------------------------------------------------
// mcsm_mul
// shared 32x32 multiplier, low half of the product registered
// ----------------------------------------------------------------------------
module mcsm_mul (
    input  logic                     i_clk,
    input  mcsm_pkg::t_mul_req       i_req,
    output logic [mcsm_pkg::DATA_W-1:0] o_prod
);
    import mcsm_pkg::*;

    logic [2*DATA_W-1:0] full_prod;
    logic [DATA_W-1:0]   r_prod;

    assign full_prod = {{DATA_W{1'b0}}, i_req.opa} * {{DATA_W{1'b0}}, i_req.opb};

    always_ff @(posedge i_clk) begin
        r_prod <= full_prod[DATA_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// ===== src/masked_code_signature_matcher.sv =====
// ----------------------------------------------------------------------------
// masked_code_signature_matcher
// masked integer-hash signature over a group of instruction words
// ----------------------------------------------------------------------------
// Each item carries one 32-bit instruction word; a group is WORDS items in
// address order. The word is masked per its two field_mask bits, run through
// an integer hash, added to the running signature and multiplied by a prime.
// After the last word one item leaves with the signature in tdata and the
// status in tuser (matched, already patched, unmatched continue or stop).
// Each input item is accepted and pre-mixed, then makes two passes through
// the single shared 32x32 multiplier (hash multiply, then the prime
// multiply), and the product is then folded into the running sum.
// s_axis_tready is high only in the idle state, so a new word is taken only
// after the previous one is folded in. The result register frees the output
// side; a group end waits only if the previous result has not been taken yet.
// ----------------------------------------------------------------------------
module masked_code_signature_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mcsm_pkg::DATA_W-1:0]       s_axis_tdata,   // [31:0] code_word
    input  logic                              s_axis_tuser,   // [0] table_select
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mcsm_pkg::DATA_W-1:0]       m_axis_tdata,   // [31:0] signature
    output logic [1:0]                        m_axis_tuser,   // [1:0] status
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [mcsm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mcsm_pkg::DATA_W-1:0]       i_cfg_data
);
    import mcsm_pkg::*;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a word
        S_MUL1 = 4'b0010,   // hash multiply in flight
        S_MUL2 = 4'b0100,   // prime multiply in flight
        S_DONE = 4'b1000    // fold product, emit at group end
    } t_state;

    // configuration registers
    logic [DATA_W-1:0] r_field_mask;
    logic [DATA_W-1:0] r_sig_b_value;
    logic              r_sig_b_valid;
    logic [DATA_W-1:0] r_sig_c_value;
    logic              r_sig_c_valid;
    logic              r_permissive;

    // group state
    t_state            r_state;
    logic [DATA_W-1:0] r_sum;
    logic [IDX_W-1:0]  r_idx;
    logic              r_first_ret;
    logic              r_patched;
    logic              r_sel;
    logic [DATA_W-1:0] r_opnd;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_sig;
    t_status           r_out_status;

    // datapath
    logic              in_accept;
    t_mask_sel         mask_sel;
    logic [DATA_W-1:0] masked_word;
    logic [DATA_W-1:0] mul_prod;
    logic [DATA_W-1:0] acc_sum;
    t_mul_req          mul_req;
    logic              is_last;
    logic              out_free;
    logic              matched;
    t_status           status;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_last       = (r_idx == LAST_IDX);
    assign out_free      = !r_out_valid || m_axis_tready;

    // word masking: two selector bits per word position
    assign mask_sel = t_mask_sel'(r_field_mask[{r_idx, 1'b0} +: 2]);

    always_comb begin
        unique case (mask_sel)
            MASK_WHOLE: masked_word = s_axis_tdata;
            MASK_UPPER: masked_word = s_axis_tdata & UPPER_MASK;
            MASK_OPC_A,
            MASK_OPC_B: masked_word = s_axis_tdata & OPCODE_MASK;
            default:    masked_word = s_axis_tdata;
        endcase
    end

    // running sum plus the finished word hash, ready for the prime multiply
    assign acc_sum = r_sum + post_mix(mul_prod);

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_IDLE: mul_req = '{opa: r_opnd,  opb: MIX_MUL};
            S_MUL1: mul_req = '{opa: r_opnd,  opb: MIX_MUL};
            S_MUL2: mul_req = '{opa: acc_sum, opb: SIG_PRIME};
            // times one keeps the final product while the group end waits
            S_DONE: mul_req = '{opa: mul_prod, opb: DATA_W'(1)};
            default: mul_req = '{opa: r_opnd, opb: MIX_MUL};
        endcase
    end

    mcsm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // table compare on the final sum
    always_comb begin
        if (r_sel) begin
            matched = r_sig_c_valid && (mul_prod == r_sig_c_value);
        end else begin
            matched = r_sig_b_valid && (mul_prod == r_sig_b_value);
        end
        priority if (r_patched) begin
            status = ST_PATCHED;
        end else if (matched) begin
            status = ST_MATCHED;
        end else if (r_permissive) begin
            status = ST_CONT;
        end else begin
            status = ST_STOP;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_mask  <= FIELD_MASK_RST;
            r_sig_b_value <= SIG_B_RST;
            r_sig_b_valid <= 1'b1;
            r_sig_c_value <= '0;
            r_sig_c_valid <= 1'b0;
            r_permissive  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIELD_MASK:  r_field_mask  <= i_cfg_data;
                CFG_SIG_B_VALUE: r_sig_b_value <= i_cfg_data;
                CFG_SIG_B_VALID: r_sig_b_valid <= i_cfg_data[0];
                CFG_SIG_C_VALUE: r_sig_c_value <= i_cfg_data;
                CFG_SIG_C_VALID: r_sig_c_valid <= i_cfg_data[0];
                CFG_PERMISSIVE:  r_permissive  <= i_cfg_data[0];
                default: ;  // indexes past the list are ignored
            endcase
        end
    end

    // operand for the hash multiply, captured with the word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_opnd <= pre_mix(masked_word);
            r_sel  <= s_axis_tuser;
        end
    end

    // sequencer and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= SUM_START;
            r_idx       <= '0;
            r_first_ret <= 1'b0;
            r_patched   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        // patch detection: return then nop at the group head
                        if (r_idx == '0) begin
                            r_first_ret <= (s_axis_tdata == RET_WORD);
                        end else if (r_idx == IDX_W'(1)) begin
                            r_patched <= r_first_ret && (s_axis_tdata == '0);
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!is_last) begin
                        r_sum   <= mul_prod;
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // result taken into the output register, new group
                        r_sum       <= SUM_START;
                        r_idx       <= '0;
                        r_first_ret <= 1'b0;
                        r_patched   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register; the product holds while the group end waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && is_last && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && is_last && out_free) begin
            r_out_sig    <= mul_prod;
            r_out_status <= status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sig;
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTH
    // word position never leaves the group
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("word index past group end");

    // an accepted word blocks the input until its hash is folded in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready while a word is in flight");

    // a result appears only from the last word of a group
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE) && ($past(r_idx) == LAST_IDX))
        else $error("result without a finished group");

    // group state is back at its start values after a result is loaded
    a_group_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && is_last && out_free |=>
            (r_idx == '0) && (r_sum == SUM_START) && !r_patched)
        else $error("group state not restarted");
`endif

endmodule
